[rtl/sgr_pkg.sv]
// sgr_pkg: shared constants, types and the dB to linear gain table
// for the stereo gain ramp block. depends on nothing.

package sgr_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int GAIN_BITS     = 9;
    localparam int LEN_BITS      = 13;
    localparam int MAX_BLOCK     = 4096;
    localparam int GAIN_SPAN     = 200;
    localparam int TABLE_SIZE    = 2 * GAIN_SPAN + 1;
    localparam int IDX_BITS      = $clog2(TABLE_SIZE);
    localparam int Q16_BITS      = 20;
    localparam int Q_EXTEND      = 12;
    localparam int RAMP_BITS     = Q16_BITS + Q_EXTEND;
    localparam int STEP_BITS     = RAMP_BITS + 1;
    localparam int FRAC_BITS     = 28;
    localparam int PRODUCT_BITS  = SAMPLE_BITS + RAMP_BITS + 1;
    localparam int DIV_STEPS     = RAMP_BITS;
    localparam int COUNT_BITS    = $clog2(DIV_STEPS);
    localparam int IN_DATA_BITS  = 72;
    localparam int OUT_DATA_BITS = 48;

    localparam logic [Q16_BITS-1:0] RESET_GAIN = 20'd92572;

    localparam logic [63:0] Q60_ONE   = 64'h1000_0000_0000_0000;
    localparam logic [63:0] UP_HIGH   = Q60_ONE + (Q60_ONE / 64'd1000) * 64'd12;
    localparam logic [63:0] DOWN_LOW  = (Q60_ONE / 64'd1000) * 64'd988;
    localparam logic [63:0] TEN_Q60   = Q60_ONE * 64'd10;
    localparam logic [63:0] TENTH_Q60 = Q60_ONE / 64'd10;
    localparam logic [63:0] ROUND_Q16 = 64'h0000_0800_0000_0000;

    typedef logic [TABLE_SIZE-1:0][Q16_BITS-1:0] gain_table_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_PREP,
        ST_DIV,
        ST_STEP,
        ST_ISSUE
    } ctrl_state_t;

    typedef struct packed {
        logic load_block;
        logic prep;
        logic div_step;
        logic set_step;
        logic issue_live;
        logic issue_hold;
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_free;
    } dp_status_t;

    // q4.60 product, truncated
    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [63:0] q60_pow(input logic [63:0] base, input int n);
        logic [63:0] v;
        v = Q60_ONE;
        for (int i = 0; i < n; i++)
        begin
            v = q60_mul(v, base);
        end
        return v;
    endfunction

    // bisection for the 200th root
    function automatic logic [63:0] q60_root(input logic [63:0] lo_in, input logic [63:0] hi_in,
                                             input logic [63:0] goal);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = lo_in;
        hi = hi_in;
        for (int it = 0; it < 64; it++)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (q60_pow(mid, GAIN_SPAN) <= goal)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic gain_table_t build_gain_table();
        gain_table_t t;
        logic [63:0] up;
        logic [63:0] down;
        logic [63:0] v;
        logic [63:0] w;
        logic [63:0] r;
        up   = q60_root(Q60_ONE, UP_HIGH, TEN_Q60);
        down = q60_root(DOWN_LOW, Q60_ONE, TENTH_Q60);
        v    = Q60_ONE;
        w    = Q60_ONE;
        t    = '0;
        for (int k = 0; k <= GAIN_SPAN; k++)
        begin
            r = (v + ROUND_Q16) >> 44;
            t[GAIN_SPAN + k] = r[Q16_BITS-1:0];
            r = (w + ROUND_Q16) >> 44;
            t[GAIN_SPAN - k] = r[Q16_BITS-1:0];
            v = q60_mul(v, up);
            w = q60_mul(w, down);
        end
        return t;
    endfunction

    localparam gain_table_t GAIN_TABLE = build_gain_table();

endpackage

[rtl/sgr_ctrl.sv]
// sgr_ctrl: sequencer for transaction acceptance, block start set-up and
// the step divider. depends on sgr_pkg.

module sgr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  first_of_block,
    input  sgr_pkg::dp_status_t   status,
    output logic                  in_ready,
    output sgr_pkg::dp_cmd_t      cmd
);

    localparam logic [sgr_pkg::COUNT_BITS-1:0] LAST_COUNT =
        sgr_pkg::COUNT_BITS'(sgr_pkg::DIV_STEPS - 1);

    sgr_pkg::ctrl_state_t state_reg;
    sgr_pkg::ctrl_state_t state_next;
    logic [sgr_pkg::COUNT_BITS-1:0] count_reg;
    logic [sgr_pkg::COUNT_BITS-1:0] count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgr_pkg::ST_RUN;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            sgr_pkg::ST_RUN:
            begin
                if (in_valid && status.pipe_free && first_of_block)
                    state_next = sgr_pkg::ST_PREP;
            end
            sgr_pkg::ST_PREP:
            begin
                state_next = sgr_pkg::ST_DIV;
                count_next = '0;
            end
            sgr_pkg::ST_DIV:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == LAST_COUNT)
                    state_next = sgr_pkg::ST_STEP;
            end
            sgr_pkg::ST_STEP:
            begin
                state_next = sgr_pkg::ST_ISSUE;
            end
            sgr_pkg::ST_ISSUE:
            begin
                if (status.pipe_free)
                    state_next = sgr_pkg::ST_RUN;
            end
            default:
            begin
                state_next = sgr_pkg::ST_RUN;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            sgr_pkg::ST_RUN:
            begin
                in_ready = status.pipe_free;
                if (in_valid && status.pipe_free)
                begin
                    cmd.load_block = first_of_block;
                    cmd.issue_live = !first_of_block;
                end
            end
            sgr_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            sgr_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            sgr_pkg::ST_STEP:
            begin
                cmd.set_step = 1'b1;
            end
            sgr_pkg::ST_ISSUE:
            begin
                cmd.issue_hold = status.pipe_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_ready_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == sgr_pkg::ST_RUN)
        else $error("ready outside run state");

    a_block_start_preps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && first_of_block) |=> state_reg == sgr_pkg::ST_PREP)
        else $error("block start did not enter set-up");

    a_divide_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sgr_pkg::ST_DIV && count_reg == LAST_COUNT)
            |=> state_reg == sgr_pkg::ST_STEP)
        else $error("divider did not finish on the last count");

endmodule

[rtl/sgr_datapath.sv]
// sgr_datapath: gain table lookup, step divider, ramp accumulator,
// multipliers and output register. depends on sgr_pkg.

module sgr_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sgr_pkg::dp_cmd_t                    cmd,
    output sgr_pkg::dp_status_t                 status,
    input  logic signed [sgr_pkg::SAMPLE_BITS-1:0] sample_1,
    input  logic signed [sgr_pkg::SAMPLE_BITS-1:0] sample_2,
    input  logic signed [sgr_pkg::GAIN_BITS-1:0]   gain_tenth_db,
    input  logic        [sgr_pkg::LEN_BITS-1:0]    block_length,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [sgr_pkg::SAMPLE_BITS-1:0] scaled_1,
    output logic signed [sgr_pkg::SAMPLE_BITS-1:0] scaled_2
);

    localparam int SB  = sgr_pkg::SAMPLE_BITS;
    localparam int RB  = sgr_pkg::RAMP_BITS;
    localparam int PB  = sgr_pkg::PRODUCT_BITS;
    localparam int LB  = sgr_pkg::LEN_BITS;
    localparam int GB  = sgr_pkg::GAIN_BITS;
    localparam int QB  = sgr_pkg::Q16_BITS;
    localparam int STB = sgr_pkg::STEP_BITS;
    localparam int FB  = sgr_pkg::FRAC_BITS;
    localparam int XB  = sgr_pkg::Q_EXTEND;

    localparam logic signed [GB-1:0] GAIN_MAX = GB'(sgr_pkg::GAIN_SPAN);
    localparam logic signed [GB-1:0] GAIN_MIN = GB'(-sgr_pkg::GAIN_SPAN);
    localparam logic [LB-1:0] LEN_MAX = LB'(sgr_pkg::MAX_BLOCK);
    localparam logic [LB-1:0] LEN_MIN = LB'(1);
    localparam logic signed [PB:0] ROUND_HALF = (PB + 1)'(64'd1 << (FB - 1));
    localparam logic signed [PB-FB:0] OUT_MAX = (PB - FB + 1)'((64'd1 << (SB - 1)) - 1);
    localparam logic signed [PB-FB:0] OUT_MIN = ~OUT_MAX;

    function automatic logic [SB-1:0] round_sat(input logic signed [PB-1:0] p);
        logic signed [PB:0]    q;
        logic signed [PB-FB:0] r;
        q = {p[PB-1], p} + ROUND_HALF;
        r = q[PB:FB];
        if (r > OUT_MAX)
            r = OUT_MAX;
        else if (r < OUT_MIN)
            r = OUT_MIN;
        return r[SB-1:0];
    endfunction

    logic [QB-1:0]  target_reg, target_next;
    logic [RB-1:0]  ramp_gain_reg, ramp_gain_next;
    logic [STB-1:0] ramp_step_reg, ramp_step_next;
    logic           pv_reg, pv_next;
    logic           ov_reg, ov_next;

    logic signed [SB-1:0] hold_1_reg, hold_1_next;
    logic signed [SB-1:0] hold_2_reg, hold_2_next;
    logic [LB-1:0]        den_reg, den_next;
    logic [LB-1:0]        rem_reg, rem_next;
    logic [RB-1:0]        quo_reg, quo_next;
    logic                 neg_reg, neg_next;
    logic signed [PB-1:0] prod_1_reg, prod_1_next;
    logic signed [PB-1:0] prod_2_reg, prod_2_next;
    logic [SB-1:0]        out_1_reg, out_1_next;
    logic [SB-1:0]        out_2_reg, out_2_next;

    logic signed [GB-1:0] gain_sat;
    logic signed [GB:0]   idx_wide;
    logic [LB-1:0]        len_sat;
    logic signed [STB-1:0] diff;
    logic [LB:0]          rem_shift;
    logic                 quo_bit;
    logic signed [SB-1:0] mul_a_1;
    logic signed [SB-1:0] mul_a_2;
    logic signed [RB+1:0] ramp_sum;
    logic signed [RB+1:0] ramp_goal;
    logic                 issue;
    logic                 out_adv;

    assign issue   = cmd.issue_live || cmd.issue_hold;
    assign out_adv = !ov_reg || out_ready;
    assign status.pipe_free = !pv_reg || out_adv;

    // block start: clamp gain and length
    always_comb
    begin
        if (gain_tenth_db > GAIN_MAX)
            gain_sat = GAIN_MAX;
        else if (gain_tenth_db < GAIN_MIN)
            gain_sat = GAIN_MIN;
        else
            gain_sat = gain_tenth_db;
        idx_wide = {gain_sat[GB-1], gain_sat} + (GB + 1)'(sgr_pkg::GAIN_SPAN);

        if (block_length < LEN_MIN)
            len_sat = LEN_MIN;
        else if (block_length > LEN_MAX)
            len_sat = LEN_MAX;
        else
            len_sat = block_length;
    end

    always_comb
    begin
        target_next    = target_reg;
        ramp_gain_next = ramp_gain_reg;
        ramp_step_next = ramp_step_reg;
        hold_1_next    = hold_1_reg;
        hold_2_next    = hold_2_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        prod_1_next    = prod_1_reg;
        prod_2_next    = prod_2_reg;

        diff      = $signed({1'b0, target_reg, {XB{1'b0}}}) - $signed({1'b0, ramp_gain_reg});
        rem_shift = {rem_reg, quo_reg[RB-1]};
        quo_bit   = rem_shift >= {1'b0, den_reg};
        mul_a_1   = cmd.issue_hold ? hold_1_reg : sample_1;
        mul_a_2   = cmd.issue_hold ? hold_2_reg : sample_2;
        ramp_goal = $signed({2'b00, target_reg, {XB{1'b0}}});
        ramp_sum  = $signed({2'b00, ramp_gain_reg})
                  + $signed({ramp_step_reg[STB-1], ramp_step_reg});

        if (cmd.load_block)
        begin
            hold_1_next    = sample_1;
            hold_2_next    = sample_2;
            den_next       = len_sat;
            target_next    = sgr_pkg::GAIN_TABLE[idx_wide[sgr_pkg::IDX_BITS-1:0]];
            ramp_gain_next = {target_reg, {XB{1'b0}}};
        end

        if (cmd.prep)
        begin
            neg_next = diff[STB-1];
            quo_next = diff[STB-1] ? RB'(-diff) : diff[RB-1:0];
            rem_next = '0;
        end

        // restoring division, one quotient bit a cycle
        if (cmd.div_step)
        begin
            rem_next = quo_bit ? LB'(rem_shift - {1'b0, den_reg}) : rem_shift[LB-1:0];
            quo_next = {quo_reg[RB-2:0], quo_bit};
        end

        if (cmd.set_step)
            ramp_step_next = neg_reg ? -{1'b0, quo_reg} : {1'b0, quo_reg};

        if (issue)
        begin
            prod_1_next = mul_a_1 * $signed({1'b0, ramp_gain_reg});
            prod_2_next = mul_a_2 * $signed({1'b0, ramp_gain_reg});
            if (!ramp_step_reg[STB-1] && ramp_step_reg != '0 && ramp_sum > ramp_goal)
                ramp_gain_next = ramp_goal[RB-1:0];
            else if (ramp_step_reg[STB-1] && ramp_sum < ramp_goal)
                ramp_gain_next = ramp_goal[RB-1:0];
            else
                ramp_gain_next = ramp_sum[RB-1:0];
        end
    end

    // product and output stages
    always_comb
    begin
        pv_next    = pv_reg;
        ov_next    = ov_reg;
        out_1_next = out_1_reg;
        out_2_next = out_2_reg;
        if (out_adv)
        begin
            ov_next    = pv_reg;
            out_1_next = round_sat(prod_1_reg);
            out_2_next = round_sat(prod_2_reg);
            pv_next    = 1'b0;
        end
        if (issue)
            pv_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= sgr_pkg::RESET_GAIN;
            ramp_gain_reg <= {sgr_pkg::RESET_GAIN, {XB{1'b0}}};
            ramp_step_reg <= '0;
            pv_reg        <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            target_reg    <= target_next;
            ramp_gain_reg <= ramp_gain_next;
            ramp_step_reg <= ramp_step_next;
            pv_reg        <= pv_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_1_reg <= hold_1_next;
        hold_2_reg <= hold_2_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        prod_1_reg <= prod_1_next;
        prod_2_reg <= prod_2_next;
        out_1_reg  <= out_1_next;
        out_2_reg  <= out_2_next;
    end

    assign out_valid = ov_reg;
    assign scaled_1  = out_1_reg;
    assign scaled_2  = out_2_reg;

    a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_block, cmd.prep, cmd.div_step, cmd.set_step,
                  cmd.issue_live, cmd.issue_hold}))
        else $error("more than one datapath command");

    a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    a_issue_fills_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> pv_reg)
        else $error("issued product lost");

endmodule

[rtl/stereo_gain_with_linear_ramp.sv]
// stereo_gain_with_linear_ramp: top level, stream ports around the
// sequencer and datapath. depends on sgr_pkg, sgr_ctrl, sgr_datapath.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: samples, gain, length; tuser: first
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: scaled pair
//
// an ordinary transaction is taken every cycle while the pipe is free; a block
// start holds the input through set-up, one-bit-a-cycle step division, step load
// and issue. products pass through the product register to the output register.
// reset is asynchronous, active low, with no clearing pass. the output register
// stalls back into the input through the product stage only when both are full.

module stereo_gain_with_linear_ramp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sample_1, sample_2, gain_tenth_db, block_length, zero pad
    input  logic [sgr_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // first_of_block
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // scaled_1, scaled_2
    output logic [sgr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);

    localparam int SB = sgr_pkg::SAMPLE_BITS;
    localparam int GB = sgr_pkg::GAIN_BITS;
    localparam int LB = sgr_pkg::LEN_BITS;

    logic signed [SB-1:0] sample_1;
    logic signed [SB-1:0] sample_2;
    logic signed [GB-1:0] gain_tenth_db;
    logic        [LB-1:0] block_length;
    logic                 first_of_block;
    logic signed [SB-1:0] scaled_1;
    logic signed [SB-1:0] scaled_2;

    sgr_pkg::dp_cmd_t    cmd;
    sgr_pkg::dp_status_t status;

    assign sample_1       = s_axis_tdata[SB-1:0];
    assign sample_2       = s_axis_tdata[2*SB-1:SB];
    assign gain_tenth_db  = s_axis_tdata[2*SB+GB-1:2*SB];
    assign block_length   = s_axis_tdata[2*SB+GB+LB-1:2*SB+GB];
    assign first_of_block = s_axis_tuser[0];
    assign m_axis_tdata   = {scaled_2, scaled_1};

    sgr_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .first_of_block (first_of_block),
        .status         (status),
        .in_ready       (s_axis_tready),
        .cmd            (cmd)
    );

    sgr_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample_1      (sample_1),
        .sample_2      (sample_2),
        .gain_tenth_db (gain_tenth_db),
        .block_length  (block_length),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .scaled_1      (scaled_1),
        .scaled_2      (scaled_2)
    );

endmodule
